// ===== rtl/vkv_pkg.sv =====
// ----------------------------------------------------------------------------
// vkv_pkg
// Shared types and codes for the versioned key/value floor lookup block.
// ----------------------------------------------------------------------------
package vkv_pkg;

   // Operation codes carried in the func field.
   localparam logic FUNC_SET = 1'b0;
   localparam logic FUNC_GET = 1'b1;

   // Result status codes.
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
   localparam logic [1:0] ST_FULL       = 2'd2;
   localparam logic [1:0] ST_NOT_RISING = 2'd3;

   // One request transaction.
   typedef struct packed {
      logic        func;
      logic [5:0]  key_slot;
      logic [30:0] stamp;
      logic [31:0] data_word;
   } req_type;

   // One response transaction.
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_word;
   } rsp_type;

endpackage

// ===== rtl/versioned_key_value_floor_lookup.sv =====
// ----------------------------------------------------------------------------
// versioned_key_value_floor_lookup
// Per-key append-only version lists with a binary-search floor lookup.
// ----------------------------------------------------------------------------
// The block handles one transaction at a time. A set that is rejected for a
// full or absent slot goes from the count read straight to the response. An
// empty slot goes straight to the append; else the last stored stamp is
// read back, and the set is rejected if that stamp is not below the new one
// and appended after it otherwise. A get runs a binary search over the slot's
// entries, each probe being one read of the entry memory followed by one
// compare, and then fetches the value; a miss skips the final value fetch. A
// new request is taken as soon as the previous result sits in the response
// register. After reset a clearing pass zeroes the per-slot entry counts, one
// slot a cycle, so no request is accepted until every slot has been cleared.
// ----------------------------------------------------------------------------
module versioned_key_value_floor_lookup #(
   parameter int KEY_SLOTS       = 64,
   parameter int ENTRIES_PER_KEY = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vkv_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vkv_pkg::rsp_type  rsp_data
);
   import vkv_pkg::*;

   localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int CNT_W  = $clog2(ENTRIES_PER_KEY + 1);
   localparam int IDX_W  = $clog2(ENTRIES_PER_KEY);
   localparam int DEPTH  = KEY_SLOTS * ENTRIES_PER_KEY;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_COUNT,
      S_PROBE,
      S_CMP,
      S_FETCH,
      S_LASTCHK,
      S_APPEND,
      S_RESP
   } state_type;

   // Memories: per-slot entry counts and the entry stamp and value stores.
   logic [CNT_W-1:0] cnt_mem   [KEY_SLOTS];
   logic [30:0]      stamp_mem [DEPTH];
   logic [31:0]      value_mem [DEPTH];

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   req_type           req_ff, req_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              range_ff, range_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic [CNT_W-1:0]  lo_save_ff, lo_save_in;
   logic [1:0]        st_ff, st_in;
   logic [31:0]       word_ff, word_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [CNT_W-1:0]  cnt_rd_ff;
   logic [30:0]       stamp_rd_ff;
   logic [31:0]       value_rd_ff;

   logic              accept;
   logic [SLOT_W+5:0] slot_ext;
   logic [CNT_W-1:0]  mid;
   logic [CNT_W-1:0]  cnt_m1;
   logic [CNT_W-1:0]  lo_m1;
   logic              cnt_we;
   logic [SLOT_W-1:0] cnt_waddr;
   logic [CNT_W-1:0]  cnt_wdata;
   logic              ent_re;
   logic [ADDR_W-1:0] ent_raddr;
   logic              ent_we;
   logic [ADDR_W-1:0] ent_waddr;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Slot index zero-extended; its low SLOT_W bits index the count memory.
   assign slot_ext = {{SLOT_W{1'b0}}, req_data.key_slot};

   // Search midpoint and the decremented indices used for last-entry and floor-entry reads.
   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign cnt_m1 = cnt_rd_ff - CNT_W'(1);
   assign lo_m1  = lo_ff - CNT_W'(1);

   // Count memory: cleared slot by slot after reset, bumped on each append.
   always_comb begin
      cnt_we    = 1'b0;
      cnt_waddr = slot_ff;
      cnt_wdata = cnt_rd_ff + CNT_W'(1);
      if (state_ff == S_CLEAR) begin
         cnt_we    = 1'b1;
         cnt_waddr = clr_ff;
         cnt_wdata = '0;
      end else if (state_ff == S_APPEND) begin
         cnt_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (accept) begin
         cnt_rd_ff <= cnt_mem[slot_ext[SLOT_W-1:0]];
      end
   end

   // Entry memory read and write addresses.
   always_comb begin
      ent_re    = 1'b0;
      ent_raddr = base_ff + ADDR_W'(mid[IDX_W-1:0]);
      ent_we    = (state_ff == S_APPEND);
      ent_waddr = base_ff + ADDR_W'(cnt_rd_ff[IDX_W-1:0]);
      case (state_ff)
         S_COUNT: begin
            ent_re    = 1'b1;
            ent_raddr = base_ff + ADDR_W'(cnt_m1[IDX_W-1:0]);
         end
         S_PROBE: begin
            ent_re = 1'b1;
            if (lo_ff == hi_ff) begin
               ent_raddr = base_ff + ADDR_W'(lo_m1[IDX_W-1:0]);
            end
         end
         default: begin
            ent_re = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         stamp_mem[ent_waddr] <= req_ff.stamp;
         value_mem[ent_waddr] <= req_ff.data_word;
      end
      if (ent_re) begin
         stamp_rd_ff <= stamp_mem[ent_raddr];
         value_rd_ff <= value_mem[ent_raddr];
      end
   end

   // The lower search bound saved before a probe; restored when the probe fails.
   assign lo_save_in = (state_ff == S_PROBE) ? lo_ff : lo_save_ff;

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_in       = req_ff;
      slot_in      = slot_ff;
      range_in     = range_ff;
      base_in      = base_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      st_in        = st_ff;
      word_in      = word_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + SLOT_W'(1);
            if (clr_ff == SLOT_W'(KEY_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               slot_in  = slot_ext[SLOT_W-1:0];
               range_in = ({{26{1'b0}}, req_data.key_slot} < 32'(KEY_SLOTS));
               base_in  = ADDR_W'(slot_ext[SLOT_W-1:0] * ENTRIES_PER_KEY);
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            word_in = '0;
            lo_in   = '0;
            hi_in   = cnt_rd_ff;
            if (!range_ff) begin
               st_in    = (req_ff.func == FUNC_SET) ? ST_FULL : ST_NOT_FOUND;
               state_in = S_RESP;
            end else if (req_ff.func == FUNC_SET) begin
               if (cnt_rd_ff >= CNT_W'(ENTRIES_PER_KEY)) begin
                  st_in    = ST_FULL;
                  state_in = S_RESP;
               end else if (cnt_rd_ff == '0) begin
                  state_in = S_APPEND;
               end else begin
                  state_in = S_LASTCHK;
               end
            end else begin
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (lo_ff != hi_ff) begin
               lo_in    = mid;
               state_in = S_CMP;
            end else if (lo_ff == '0) begin
               st_in    = ST_NOT_FOUND;
               state_in = S_RESP;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_CMP: begin
            // The probed index is held in lo_ff for this cycle; a probe above
            // the query brings back the saved lower bound.
            if (stamp_rd_ff <= req_ff.stamp) begin
               lo_in = lo_ff + CNT_W'(1);
            end else begin
               hi_in = lo_ff;
               lo_in = lo_save_ff;
            end
            state_in = S_PROBE;
         end
         S_FETCH: begin
            st_in    = ST_OK;
            word_in  = value_rd_ff;
            state_in = S_RESP;
         end
         S_LASTCHK: begin
            if (req_ff.stamp <= stamp_rd_ff) begin
               st_in    = ST_NOT_RISING;
               state_in = S_RESP;
            end else begin
               state_in = S_APPEND;
            end
         end
         S_APPEND: begin
            st_in    = ST_OK;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = st_ff;
               rsp_in.read_word = word_ff;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, search registers and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff     <= req_in;
      slot_ff    <= slot_in;
      range_ff   <= range_in;
      base_ff    <= base_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      lo_save_ff <= lo_save_in;
      st_ff      <= st_in;
      word_ff    <= word_in;
      rsp_ff     <= rsp_in;
   end

   // An accepted request always starts with the count read.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_COUNT))
      else $error("accepted request did not move to the count read");

   // The search window never inverts and never exceeds the entries per key.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> (lo_ff <= hi_ff) && (hi_ff <= CNT_W'(ENTRIES_PER_KEY)))
      else $error("binary-search window out of order");

   // An append only happens into a slot that still has room.
   assert property (@(posedge clock) disable iff (reset)
      ent_we |-> (cnt_rd_ff < CNT_W'(ENTRIES_PER_KEY)) && range_ff)
      else $error("append into a full or absent slot");

   // Only a successful get carries a non-zero value word.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != ST_OK)) |-> (rsp_ff.read_word == '0))
      else $error("non-zero value word on a failed transaction");

endmodule

// ===== bench/versioned_key_value_floor_lookup_tb.sv =====
// ----------------------------------------------------------------------------
// versioned_key_value_floor_lookup_tb
// Self-checking bench for the versioned key/value floor lookup block. A short
// table of directed transactions is followed by random traffic that builds up
// per-key version lists, fills one slot to capacity and queries the lists at
// and around the stored stamps. Each response is compared with a hand-written
// one for directed rows that give it, else with a behavioural model of the
// store kept alongside the block. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module versioned_key_value_floor_lookup_tb;
   import vkv_pkg::*;

   localparam int SLOTS        = 64;
   localparam int ENTRIES      = 256;
   localparam int RANDOM_ITEMS = 1600;
   localparam int HOT_COUNT    = 6;
   localparam int DIRECTED     = 18;
   localparam bit [31:0] STAMP_MAX  = 32'h7FFF_FFFF;
   localparam bit [31:0] STAMP_MASK = 32'h7FFF_FFFF;

   // One line of the directed table: the request, and a hand-written response
   // where the expected value is obvious.
   typedef struct packed {
      logic    typed;
      req_type item;
      rsp_type want;
   } row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Mirror of the store: entry counts and the version lists of every slot.
   int unsigned entry_total [SLOTS];
   bit [30:0]   stamp_store [SLOTS][ENTRIES];
   bit [31:0]   value_store [SLOTS][ENTRIES];

   rsp_type     pending_replies [$];
   rsp_type     oldest_reply;
   int unsigned hot_slots [HOT_COUNT];
   int          failures;
   int          stall_left;
   bit          no_idle;

   row_type directed_rows [DIRECTED] = '{
      '{1'b1, '{FUNC_GET, 6'd0,  31'h7FFF_FFFF, 32'h0000_0000}, '{ST_NOT_FOUND,  32'h0}},
      '{1'b1, '{FUNC_GET, 6'd63, 31'h0000_0000, 32'hFFFF_FFFF}, '{ST_NOT_FOUND,  32'h0}},
      '{1'b1, '{FUNC_SET, 6'd0,  31'h0000_0000, 32'hFFFF_FFFF}, '{ST_OK,         32'h0}},
      '{1'b1, '{FUNC_GET, 6'd0,  31'h0000_0000, 32'h0000_0000}, '{ST_OK, 32'hFFFF_FFFF}},
      '{1'b1, '{FUNC_SET, 6'd0,  31'h0000_0000, 32'h0000_0001}, '{ST_NOT_RISING, 32'h0}},
      '{1'b1, '{FUNC_SET, 6'd0,  31'd100,       32'h1234_5678}, '{ST_OK,         32'h0}},
      '{1'b1, '{FUNC_SET, 6'd0,  31'd50,        32'h0BAD_F00D}, '{ST_NOT_RISING, 32'h0}},
      '{1'b0, '{FUNC_GET, 6'd0,  31'd99,        32'h0000_0000}, '{ST_OK,         32'h0}},
      '{1'b1, '{FUNC_GET, 6'd0,  31'd100,       32'h0000_0000}, '{ST_OK, 32'h1234_5678}},
      '{1'b1, '{FUNC_GET, 6'd0,  31'h7FFF_FFFF, 32'h0000_0000}, '{ST_OK, 32'h1234_5678}},
      '{1'b1, '{FUNC_SET, 6'd63, 31'h7FFF_FFFF, 32'h0000_0000}, '{ST_OK,         32'h0}},
      '{1'b1, '{FUNC_SET, 6'd63, 31'h7FFF_FFFF, 32'hAAAA_5555}, '{ST_NOT_RISING, 32'h0}},
      '{1'b1, '{FUNC_GET, 6'd63, 31'h7FFF_FFFE, 32'h0000_0000}, '{ST_NOT_FOUND,  32'h0}},
      '{1'b1, '{FUNC_GET, 6'd63, 31'h7FFF_FFFF, 32'h0000_0000}, '{ST_OK,         32'h0}},
      '{1'b1, '{FUNC_SET, 6'd1,  31'd10,        32'h5555_5555}, '{ST_OK,         32'h0}},
      '{1'b1, '{FUNC_GET, 6'd1,  31'd9,         32'h0000_0000}, '{ST_NOT_FOUND,  32'h0}},
      '{1'b1, '{FUNC_GET, 6'd1,  31'd10,        32'hFFFF_FFFF}, '{ST_OK, 32'h5555_5555}},
      '{1'b0, '{FUNC_SET, 6'd42, 31'h5555_5555, 32'hA5A5_A5A5}, '{ST_OK,         32'h0}}
   };

   versioned_key_value_floor_lookup #(
      .KEY_SLOTS       (SLOTS),
      .ENTRIES_PER_KEY (ENTRIES)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // Works out the response to one transaction and updates the mirrored store.
   function automatic rsp_type compute_reply(input req_type item);
      rsp_type     reply;
      int unsigned slot;
      int unsigned n;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      reply.status    = ST_OK;
      reply.read_word = '0;
      slot = item.key_slot;
      if (item.func == FUNC_SET) begin
         if (slot >= SLOTS || entry_total[slot] >= ENTRIES) begin
            reply.status = ST_FULL;
         end else begin
            n = entry_total[slot];
            if (n > 0 && item.stamp <= stamp_store[slot][n - 1]) begin
               reply.status = ST_NOT_RISING;
            end else begin
               stamp_store[slot][n] = item.stamp;
               value_store[slot][n] = item.data_word;
               entry_total[slot]    = n + 1;
            end
         end
      end else if (slot >= SLOTS) begin
         reply.status = ST_NOT_FOUND;
      end else begin
         // Find the first entry whose stamp lies above the query.
         lo = 0;
         hi = entry_total[slot];
         while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (stamp_store[slot][mid] <= item.stamp) begin
               lo = mid + 1;
            end else begin
               hi = mid;
            end
         end
         if (lo == 0) begin
            reply.status = ST_NOT_FOUND;
         end else begin
            reply.read_word = value_store[slot][lo - 1];
         end
      end
      return reply;
   endfunction

   // Idle length in cycles: mostly none or short, now and then a long one.
   function automatic int idle_gap();
      int pick;
      if (no_idle) begin
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         return 0;
      end else if (pick < 90) begin
         return $urandom_range(1, 3);
      end else if (pick < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Offers one request transaction and records its expected response once the
   // block has taken it. The valid line stays high when no gap follows.
   task automatic send_item(input req_type item, input bit typed, input rsp_type want);
      int      gap;
      rsp_type predicted;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predicted = compute_reply(item);
      if (typed) begin
         predicted = want;
      end
      pending_replies = {pending_replies, predicted};
      gap = idle_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Builds a random request, mostly on a few busy slots, with stamps placed
   // around what the slot already holds so that lookups hit every outcome.
   task automatic make_item(output req_type item);
      int unsigned slot;
      int unsigned n;
      int unsigned pick;
      bit [31:0]   last;
      bit [31:0]   probe;
      if ($urandom_range(0, 3) != 0) begin
         slot = hot_slots[$urandom_range(0, HOT_COUNT - 1)];
      end else begin
         slot = $urandom_range(0, SLOTS - 1);
      end
      n    = entry_total[slot];
      pick = $urandom_range(0, 99);
      item.key_slot  = slot[5:0];
      item.data_word = $urandom;
      if ($urandom_range(0, 1) == 0) begin
         item.func = FUNC_SET;
         last = (n == 0) ? 32'd0 : {1'b0, stamp_store[slot][n - 1]};
         if (n == 0) begin
            probe = (pick < 50) ? $urandom_range(0, 1000) : ($urandom & STAMP_MASK);
         end else if (pick < 75) begin
            probe = last + $urandom_range(1, 64);
         end else if (pick < 85) begin
            probe = last;
         end else if (pick < 92) begin
            probe = (last == 0) ? 32'd0 : $urandom_range(0, last - 1);
         end else begin
            probe = $urandom & STAMP_MASK;
         end
         if (probe > STAMP_MAX) begin
            probe = $urandom & STAMP_MASK;
         end
      end else begin
         item.func = FUNC_GET;
         if (n == 0) begin
            probe = (pick < 50) ? $urandom_range(0, 1000) : ($urandom & STAMP_MASK);
         end else begin
            last = {1'b0, stamp_store[slot][$urandom_range(0, n - 1)]};
            if (pick < 40) begin
               probe = last;
            end else if (pick < 65) begin
               probe = last + $urandom_range(0, 3);
            end else if (pick < 75) begin
               // Just below the oldest entry of the slot.
               probe = (stamp_store[slot][0] == 0) ? 32'd0 : stamp_store[slot][0] - 1;
            end else if (pick < 85) begin
               probe = STAMP_MAX;
            end else if (pick < 92) begin
               probe = 32'd0;
            end else begin
               probe = $urandom & STAMP_MASK;
            end
            if (probe > STAMP_MAX) begin
               probe = STAMP_MAX;
            end
         end
      end
      item.stamp = probe[30:0];
   endtask

   // Appends to one slot until it is full, with lookups mixed in, then keeps
   // sending sets and gets to it so that rejected sets on a full slot are seen.
   task automatic fill_burst();
      int unsigned start;
      int unsigned slot;
      int unsigned k;
      bit [31:0]   last;
      req_type     item;
      start = $urandom_range(0, SLOTS - 1);
      k = 0;
      slot = start;
      // Pick a slot whose last stamp leaves plenty of headroom.
      while (k < SLOTS && entry_total[slot] != 0 &&
             stamp_store[slot][entry_total[slot] - 1] >= 31'h4000_0000) begin
         k = k + 1;
         slot = (start + k) % SLOTS;
      end
      item.key_slot = slot[5:0];
      while (entry_total[slot] < ENTRIES) begin
         last = (entry_total[slot] == 0) ? 32'd0 :
                {1'b0, stamp_store[slot][entry_total[slot] - 1]};
         item.data_word = $urandom;
         if ($urandom_range(0, 7) == 0) begin
            item.func  = FUNC_GET;
            item.stamp = 31'($urandom_range(0, last + 500));
         end else begin
            item.func  = FUNC_SET;
            item.stamp = 31'(last + $urandom_range(1, 1000));
         end
         send_item(item, 1'b0, '0);
      end
      repeat (24) begin
         item.func      = ($urandom_range(0, 1) == 0) ? FUNC_SET : FUNC_GET;
         item.stamp     = ($urandom_range(0, 3) == 0) ? STAMP_MAX[30:0] : 31'($urandom);
         item.data_word = $urandom;
         send_item(item, 1'b0, '0);
      end
   endtask

   // Response side: compare each accepted transaction with the oldest
   // expectation, then choose whether to stall for the next cycles.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            failures = failures + 1;
            $display("%0t: response with nothing expected: status %0d word %h",
                     $time, rsp_data.status, rsp_data.read_word);
         end else begin
            oldest_reply = pending_replies.pop_front();
            if (oldest_reply.status != rsp_data.status) begin
               failures = failures + 1;
               if (failures < 50) begin
                  $display("%0t: status mismatch: expected %0d actual %0d",
                           $time, oldest_reply.status, rsp_data.status);
               end
            end
            if (oldest_reply.read_word != rsp_data.read_word) begin
               failures = failures + 1;
               if (failures < 50) begin
                  $display("%0t: read_word mismatch: expected %h actual %h",
                           $time, oldest_reply.read_word, rsp_data.read_word);
               end
            end
         end
      end
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready  <= 1'b1;
         stall_left <= ($urandom_range(0, 3) == 0) ? idle_gap() : 0;
      end
   end

   // Stimulus: reset, the directed table, then random traffic.
   initial begin : stimulus
      req_type item;
      int      i;
      clock      = 1'b0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      rsp_ready  = 1'b0;
      failures   = 0;
      stall_left = 0;
      no_idle    = 1'b0;
      for (i = 0; i < SLOTS; i++) begin
         entry_total[i] = 0;
      end
      for (i = 0; i < HOT_COUNT; i++) begin
         hot_slots[i] = $urandom_range(0, SLOTS - 1);
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED; i++) begin
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 300 == 0) begin
            no_idle = (i != 0) && ($urandom_range(0, 3) == 0);
         end
         if (i == 400) begin
            fill_burst();
         end
         // Hold the sender off until the block has answered everything.
         if (i == 900) begin
            req_valid <= 1'b0;
            while (pending_replies.size() != 0) begin
               @(posedge clock);
            end
         end
         make_item(item);
         send_item(item, 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (pending_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (32) @(posedge clock);
      if (failures == 0 && pending_replies.size() == 0) begin
         $display("versioned_key_value_floor_lookup verification clean");
      end else begin
         $display("versioned_key_value_floor_lookup verification failed");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #(8 * 1200000);
      $display("versioned_key_value_floor_lookup verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/vkv_pkg.sv
rtl/versioned_key_value_floor_lookup.sv
bench/versioned_key_value_floor_lookup_tb.sv
